/* rtl/vfcm_pkg.sv */
// Package: shared types, commands and constants of the voxel face mesher.
`default_nettype none
package vfcm_pkg;
  localparam int GridEdgeDef = 32;
  localparam int PaletteDepthDef = 256;
  localparam int CoordW = 8;
  localparam int SizeW = 6;
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_LOAD = 3'd1,
    CMD_PAL = 3'd2,
    CMD_EMIT = 3'd3,
    CMD_REPORT = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_PROBE = 2'd1,
    BK_FACE = 2'd2
  } bk_state_t;

  // one queued word from front to back
  typedef struct packed {
    logic [2:0] cmd;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic [CoordW-1:0] ci;
    logic [31:0] rgba;
  } job_t;

  // box bounds wide enough for any grid edge up to 64
  typedef struct packed {
    logic [SizeW-1:0] min_x;
    logic [SizeW-1:0] max_x;
    logic [SizeW-1:0] min_y;
    logic [SizeW-1:0] max_y;
    logic [SizeW-1:0] min_z;
    logic [SizeW-1:0] max_z;
    logic any;
  } box_t;

  // shade factor per face
  function automatic logic [8:0] face_shade(input logic [2:0] d);
    case (d)
      3'd0, 3'd1: face_shade = 9'd200;
      3'd2, 3'd3: face_shade = 9'd159;
      3'd4: face_shade = 9'd256;
      default: face_shade = 9'd128;
    endcase
  endfunction
endpackage
`default_nettype wire

/* rtl/vfcm_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module vfcm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(Depth)-1:0] addr,
  input wire logic [Width-1:0] wdata,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* rtl/vfcm_front.sv */
// Front end: takes command words, queues them for the back end.
`default_nettype none
module vfcm_front import vfcm_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic [2:0] in_cmd,
  input wire logic [CoordW-1:0] in_coord_x,
  input wire logic [CoordW-1:0] in_coord_y,
  input wire logic [CoordW-1:0] in_coord_z,
  input wire logic [CoordW-1:0] in_color_index,
  input wire logic [31:0] in_palette_rgba,
  output logic busy,
  output logic q_valid,
  output job_t q_job,
  input wire logic q_pop
);
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam int PtrW = $clog2(QueueDepth);
  job_t q_r [QueueDepth];
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [PtrW-1:0] rd_r, wr_r;
  logic push;

  assign busy = (cnt_r == CntW'(QueueDepth));
  assign push = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_job = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= '0;
      wr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= wr_r + 1'b1;
      if (q_pop) rd_r <= rd_r + 1'b1;
    end
    if (push) begin
      q_r[wr_r] <= '{cmd: in_cmd, x: in_coord_x, y: in_coord_y, z: in_coord_z,
                     ci: in_color_index, rgba: in_palette_rgba};
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(QueueDepth)) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CntW'(QueueDepth)) |-> busy) else $error("full but not busy");
endmodule
`default_nettype wire

/* rtl/vfcm_back.sv */
// Back end: occupancy grid, palette, box and vertex generation.
`default_nettype none
module vfcm_back import vfcm_pkg::*; #(
  parameter int GridEdge = GridEdgeDef,
  parameter int PaletteDepth = PaletteDepthDef
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic [SizeW-1:0] size_x,
  input wire logic [SizeW-1:0] size_y,
  input wire logic [SizeW-1:0] size_z,
  input wire logic q_valid,
  input wire job_t q_job,
  output logic q_pop,
  output logic clearing,
  output logic out_valid,
  output logic signed [7:0] out_vert_x,
  output logic [6:0] out_vert_y,
  output logic signed [7:0] out_vert_z,
  output logic [2:0] out_face_dir,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic out_last,
  output logic [5:0] out_content_height,
  output logic out_has_content
);
  localparam int EW = $clog2(GridEdge);
  localparam int RowW = 2 * EW;
  localparam int PW = $clog2(PaletteDepth);
  localparam logic [SizeW:0] EdgeC = (SizeW + 1)'(GridEdge);

  // occupancy: one row of GridEdge bits per (z,y)
  logic occ_we;
  logic [RowW-1:0] occ_addr;
  logic [GridEdge-1:0] occ_wd, occ_rd;
  vfcm_ram #(.Width(GridEdge), .Depth(1 << RowW)) u_occ (
    .clk, .we(occ_we), .addr(occ_addr), .wdata(occ_wd), .rdata(occ_rd));

  logic pal_we;
  logic [PW-1:0] pal_addr;
  logic [31:0] pal_rd;
  vfcm_ram #(.Width(32), .Depth(PaletteDepth)) u_pal (
    .clk, .we(pal_we), .addr(pal_addr), .wdata(q_job.rgba), .rdata(pal_rd));

  bk_state_t st_r, st_nxt;
  job_t j_r;
  box_t box_r, box_nxt;
  logic clr_r, clr_nxt;
  logic [RowW-1:0] cptr_r, cptr_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [5:0] open_r, open_nxt;
  logic [5:0] fwd_r, fwd_nxt;
  logic [2:0] d_r, d_nxt;
  logic [2:0] k_r, k_nxt;

  logic [SizeW:0] ex, ey, ez;
  always_comb begin
    ex = ({1'b0, size_x} > EdgeC) ? EdgeC : {1'b0, size_x};
    ey = ({1'b0, size_y} > EdgeC) ? EdgeC : {1'b0, size_y};
    ez = ({1'b0, size_z} > EdgeC) ? EdgeC : {1'b0, size_z};
  end

  function automatic logic inside_grid(input logic [8:0] a, input logic [SizeW:0] e);
    inside_grid = (a < {2'b0, e});
  endfunction

  logic jin, qin;
  assign jin = inside_grid({1'b0, j_r.x}, ex) && inside_grid({1'b0, j_r.y}, ey) &&
               inside_grid({1'b0, j_r.z}, ez);
  assign qin = inside_grid({1'b0, q_job.x}, ex) && inside_grid({1'b0, q_job.y}, ey) &&
               inside_grid({1'b0, q_job.z}, ez);

  // probe step: 0 own row, 1 y+1, 2 y-1, 3 z+1, 4 and 5 z-1; each row used a step later
  logic [8:0] py, pz;
  logic [EW-1:0] xi;
  assign xi = j_r.x[EW-1:0];

  logic [RowW-1:0] job_row;
  assign job_row = {q_job.z[EW-1:0], q_job.y[EW-1:0]};

  // outputs
  logic ov_nxt, olast_nxt, ohas_nxt;
  logic signed [7:0] ovx_nxt, ovz_nxt;
  logic [6:0] ovy_nxt;
  logic [2:0] od_nxt;
  logic [7:0] or_nxt, og_nxt, ob_nxt, oa_nxt;
  logic [5:0] och_nxt;

  logic signed [9:0] x0, z0, y0s, vxs, vys, vzs;
  logic [1:0] corner;
  logic hx, hy, hz;
  logic [8:0] sh;
  logic [16:0] pr, pg, pb;
  logic [5:0] rem_open;

  always_comb begin
    x0 = 10'(signed'({2'b0, j_r.x})) * 10'sd2 -
         10'(signed'({3'b0, {1'b0, box_r.min_x} + {1'b0, box_r.max_x} + 7'd1}));
    z0 = 10'(signed'({2'b0, j_r.y})) * 10'sd2 -
         10'(signed'({3'b0, {1'b0, box_r.min_y} + {1'b0, box_r.max_y} + 7'd1}));
    y0s = (10'(signed'({2'b0, j_r.z})) - 10'(signed'({4'b0, box_r.min_z}))) * 10'sd2;
    case (k_r)
      3'd0, 3'd3: corner = 2'd0;
      3'd1: corner = 2'd1;
      3'd2, 3'd4: corner = 2'd2;
      default: corner = 2'd3;
    endcase
    hx = 1'b0; hy = 1'b0; hz = 1'b0;
    case (d_r)
      3'd0: begin hx = 1'b1; hy = corner == 2'd1 || corner == 2'd2;
        hz = corner == 2'd2 || corner == 2'd3; end
      3'd1: begin hy = corner == 2'd1 || corner == 2'd2;
        hz = corner == 2'd0 || corner == 2'd1; end
      3'd2: begin hz = 1'b1; hx = corner == 2'd1 || corner == 2'd2;
        hy = corner == 2'd2 || corner == 2'd3; end
      3'd3: begin hx = corner == 2'd0 || corner == 2'd3;
        hy = corner == 2'd2 || corner == 2'd3; end
      3'd4: begin hy = 1'b1; hx = corner == 2'd2 || corner == 2'd3;
        hz = corner == 2'd1 || corner == 2'd2; end
      default: begin hx = corner == 2'd2 || corner == 2'd3;
        hz = corner == 2'd0 || corner == 2'd3; end
    endcase
    vxs = x0 + (hx ? 10'sd2 : 10'sd0);
    vys = y0s + (hy ? 10'sd2 : 10'sd0);
    vzs = z0 + (hz ? 10'sd2 : 10'sd0);
    sh = face_shade(d_r);
    pr = pal_rd[7:0] * sh;
    pg = pal_rd[15:8] * sh;
    pb = pal_rd[23:16] * sh;
    rem_open = open_r & ~((6'd2 << d_r) - 6'd1);
  end

  always_comb begin
    st_nxt = st_r;
    box_nxt = box_r;
    clr_nxt = clr_r;
    cptr_nxt = cptr_r;
    ph_nxt = ph_r;
    open_nxt = open_r;
    fwd_nxt = fwd_r;
    d_nxt = d_r;
    k_nxt = k_r;
    q_pop = 1'b0;
    occ_we = 1'b0;
    occ_addr = job_row;
    occ_wd = occ_rd;
    pal_we = 1'b0;
    pal_addr = j_r.ci - ((j_r.ci != '0) ? 8'd1 : 8'd0);
    ov_nxt = 1'b0; olast_nxt = 1'b0; ohas_nxt = 1'b0;
    ovx_nxt = '0; ovy_nxt = '0; ovz_nxt = '0; od_nxt = '0;
    or_nxt = '0; og_nxt = '0; ob_nxt = '0; oa_nxt = '0; och_nxt = '0;
    py = {1'b0, j_r.y}; pz = {1'b0, j_r.z};
    if (clr_r) begin
      occ_we = 1'b1;
      occ_addr = cptr_r;
      occ_wd = '0;
      cptr_nxt = cptr_r + 1'b1;
      if (cptr_r == '1) clr_nxt = 1'b0;
    end else begin
      case (st_r)
        BK_IDLE: begin
          if (q_valid) begin
            q_pop = 1'b1;
            case (q_job.cmd)
              CMD_CLEAR: begin
                box_nxt = '0;
                clr_nxt = 1'b1;
                cptr_nxt = '0;
              end
              CMD_LOAD: begin
                if (qin) begin
                  st_nxt = BK_PROBE;
                  ph_nxt = 2'd3;
                  if (!box_r.any) begin
                    box_nxt = '{q_job.x[SizeW-1:0], q_job.x[SizeW-1:0],
                               q_job.y[SizeW-1:0], q_job.y[SizeW-1:0],
                               q_job.z[SizeW-1:0], q_job.z[SizeW-1:0], 1'b1};
                  end else begin
                    if (q_job.x[SizeW-1:0] < box_r.min_x) box_nxt.min_x = q_job.x[SizeW-1:0];
                    if (q_job.x[SizeW-1:0] > box_r.max_x) box_nxt.max_x = q_job.x[SizeW-1:0];
                    if (q_job.y[SizeW-1:0] < box_r.min_y) box_nxt.min_y = q_job.y[SizeW-1:0];
                    if (q_job.y[SizeW-1:0] > box_r.max_y) box_nxt.max_y = q_job.y[SizeW-1:0];
                    if (q_job.z[SizeW-1:0] < box_r.min_z) box_nxt.min_z = q_job.z[SizeW-1:0];
                    if (q_job.z[SizeW-1:0] > box_r.max_z) box_nxt.max_z = q_job.z[SizeW-1:0];
                  end
                end
              end
              CMD_PAL: begin
                pal_we = 1'b1;
                pal_addr = q_job.ci;
              end
              CMD_REPORT: begin
                ov_nxt = 1'b1; olast_nxt = 1'b1;
                ohas_nxt = box_r.any;
                if (box_r.any) och_nxt = 6'({1'b0, box_r.max_z} - {1'b0, box_r.min_z} + 7'd1);
              end
              CMD_EMIT: begin
                if (qin) begin
                  st_nxt = BK_PROBE;
                  ph_nxt = 2'd0;
                  open_nxt = '0;
                end
              end
              default: ;
            endcase
          end
        end
        BK_PROBE: begin
          // load: own row only; emit: row of the voxel, then y+1, y-1, z+1, z-1; RAM read is registered
          if (j_r.cmd == CMD_LOAD) begin
            occ_addr = {j_r.z[EW-1:0], j_r.y[EW-1:0]};
            if (ph_r == 2'd3) begin
              ph_nxt = 2'd2;
            end else begin
              occ_we = 1'b1;
              occ_wd = occ_rd | (GridEdge'(1) << xi);
              st_nxt = BK_IDLE;
            end
          end else begin
            case (fwd_r)
              6'd0: begin py = {1'b0, j_r.y}; end
              6'd1: begin py = {1'b0, j_r.y} + 9'd1; end
              6'd2: begin py = {1'b0, j_r.y} - 9'd1; end
              6'd3: begin pz = {1'b0, j_r.z} + 9'd1; end
              default: begin pz = {1'b0, j_r.z} - 9'd1; end
            endcase
            occ_addr = {pz[EW-1:0], py[EW-1:0]};
            fwd_nxt = fwd_r + 6'd1;
            // consume the row read last cycle
            if (fwd_r != 6'd0) begin
              case (fwd_r)
                6'd1: begin
                  open_nxt[0] = !inside_grid({1'b0, j_r.x} + 9'd1, ex) || !occ_rd[xi + 1'b1];
                  open_nxt[1] = (j_r.x == '0) || !occ_rd[xi - 1'b1];
                end
                6'd2: open_nxt[2] = !inside_grid({1'b0, j_r.y} + 9'd1, ey) || !occ_rd[xi];
                6'd3: open_nxt[3] = (j_r.y == '0) || !occ_rd[xi];
                6'd4: open_nxt[4] = !inside_grid({1'b0, j_r.z} + 9'd1, ez) || !occ_rd[xi];
                default: begin
                  open_nxt[5] = (j_r.z == '0) || !occ_rd[xi];
                  st_nxt = BK_FACE;
                  d_nxt = '0;
                  k_nxt = '0;
                end
              endcase
            end
          end
        end
        BK_FACE: begin
          if (!open_r[d_r]) begin
            if (d_r == 3'd5) st_nxt = BK_IDLE;
            d_nxt = d_r + 3'd1;
          end else begin
            ov_nxt = 1'b1;
            ovx_nxt = vxs[7:0];
            ovz_nxt = vzs[7:0];
            ovy_nxt = (vys < 0) ? 7'd0 : ((vys > 10'sd127) ? 7'd127 : vys[6:0]);
            od_nxt = d_r;
            or_nxt = pr[15:8]; og_nxt = pg[15:8]; ob_nxt = pb[15:8];
            oa_nxt = pal_rd[31:24];
            k_nxt = k_r + 3'd1;
            if (k_r == 3'd5) begin
              k_nxt = '0;
              d_nxt = d_r + 3'd1;
              if (rem_open == '0) begin
                olast_nxt = 1'b1;
                st_nxt = BK_IDLE;
              end
            end
          end
        end
        default: st_nxt = BK_IDLE;
      endcase
    end
    if (st_r == BK_IDLE && st_nxt == BK_PROBE) fwd_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      box_r <= '0;
      clr_r <= 1'b1;
      cptr_r <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      box_r <= box_nxt;
      clr_r <= clr_nxt;
      cptr_r <= cptr_nxt;
      out_valid <= ov_nxt;
    end
    ph_r <= ph_nxt;
    open_r <= open_nxt;
    fwd_r <= fwd_nxt;
    d_r <= d_nxt;
    k_r <= k_nxt;
    if (q_pop) j_r <= q_job;
    out_vert_x <= ovx_nxt; out_vert_y <= ovy_nxt; out_vert_z <= ovz_nxt;
    out_face_dir <= od_nxt; out_red <= or_nxt; out_green <= og_nxt;
    out_blue <= ob_nxt; out_alpha <= oa_nxt; out_last <= olast_nxt;
    out_content_height <= och_nxt; out_has_content <= ohas_nxt;
  end

  assign clearing = clr_r;

  a_emit_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_FACE) |-> jin) else $error("face stage for voxel outside grid");
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid) else $error("last without valid");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == BK_IDLE && !clr_r)) else $error("pop while busy");
endmodule
`default_nettype wire

/* rtl/voxel_face_culling_mesher.sv */
// Top level of the voxel face-culling mesher.
`default_nettype none
// Use: issue command words with start; a word is taken when start is high and
// busy is low. Commands: clear, load voxel, palette write, emit voxel faces,
// report. Results appear on out_* for one cycle with out_valid; the receiver
// cannot stall, so every result must be captured when shown.
// A two-entry queue parts the command front end from the back end.
// Load: a read-modify-write of an occupancy row in the back end.
// Palette write and report are done in the dispatch step. Emit: a dispatch step
// and probe steps over occupancy rows (own row, y+1, y-1, z+1, z-1), then one
// vertex per cycle and a step per closed face ahead of the last open one; a voxel
// outside the grid ends at dispatch with no output.
// Clear and reset: a sweep of one occupancy row per cycle (1024 rows at the default
// edge of 32) zeroes the occupancy RAM; no command is carried out then.
// Size registers are written over the cfg_ APB port at 4*index; reset 32.
module voxel_face_culling_mesher import vfcm_pkg::*; #(
  parameter int GRID_EDGE = GridEdgeDef,
  parameter int PALETTE_DEPTH = PaletteDepthDef
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  output logic busy,
  input wire logic [2:0] in_cmd,
  input wire logic [7:0] in_coord_x,
  input wire logic [7:0] in_coord_y,
  input wire logic [7:0] in_coord_z,
  input wire logic [7:0] in_color_index,
  input wire logic [31:0] in_palette_rgba,
  output logic out_valid,
  output logic signed [7:0] out_vert_x,
  output logic [6:0] out_vert_y,
  output logic signed [7:0] out_vert_z,
  output logic [2:0] out_face_dir,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic out_last,
  output logic [5:0] out_content_height,
  output logic out_has_content,
  input wire logic cfg_psel,
  input wire logic cfg_penable,
  input wire logic cfg_pwrite,
  input wire logic [3:0] cfg_paddr,
  input wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  logic [SizeW-1:0] size_x_r, size_y_r, size_z_r;
  logic wr;
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= 6'd32; size_y_r <= 6'd32; size_z_r <= 6'd32;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      case (cfg_paddr[3:2])
        REG_SIZE_X: size_x_r <= cfg_pwdata[5:0];
        REG_SIZE_Y: size_y_r <= cfg_pwdata[5:0];
        REG_SIZE_Z: size_z_r <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_SIZE_X: cfg_prdata = {26'd0, size_x_r};
      REG_SIZE_Y: cfg_prdata = {26'd0, size_y_r};
      REG_SIZE_Z: cfg_prdata = {26'd0, size_z_r};
      default: cfg_prdata = '0;
    endcase
  end

  logic q_valid, q_pop, clearing, fbusy;
  job_t q_job;
  assign busy = fbusy;

  vfcm_front u_front (
    .clk, .rst_n, .start, .in_cmd, .in_coord_x, .in_coord_y, .in_coord_z,
    .in_color_index, .in_palette_rgba, .busy(fbusy), .q_valid, .q_job, .q_pop);

  vfcm_back #(.GridEdge(GRID_EDGE), .PaletteDepth(PALETTE_DEPTH)) u_back (
    .clk, .rst_n, .size_x(size_x_r), .size_y(size_y_r), .size_z(size_z_r),
    .q_valid, .q_job, .q_pop, .clearing, .out_valid, .out_vert_x, .out_vert_y,
    .out_vert_z, .out_face_dir, .out_red, .out_green, .out_blue, .out_alpha,
    .out_last, .out_content_height, .out_has_content);

  a_no_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |=> !out_valid) else $error("result during clear sweep");
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for the voxel face-culling mesher: scoreboarded random and directed runs.
`timescale 1ns / 1ps
module tb_top;
  import vfcm_pkg::*;

  localparam int Edge = 32;
  localparam int WatchLimit = 20000;
  localparam int SettleCycles = 1200;

  typedef struct {
    logic [2:0] cmd;
    logic [7:0] x, y, z, ci;
    logic [31:0] rgba;
  } word_t;

  typedef struct packed {
    logic [7:0] vx;
    logic [6:0] vy;
    logic [7:0] vz;
    logic [2:0] dir;
    logic [7:0] r, g, b, a;
    logic last;
    logic [5:0] height;
    logic has;
  } vertex_t;

  class mesh_scoreboard;
    bit occ[Edge*Edge*Edge];
    logic [31:0] palette[256];
    int sx, sy, sz;
    int bminx, bmaxx, bminy, bmaxy, bminz, bmaxz;
    bit loaded;
    vertex_t pending[$];
    int fails;

    function new();
      sx = 32; sy = 32; sz = 32;
      fails = 0;
      wipe();
      foreach (palette[i]) palette[i] = '0;
    endfunction

    function void wipe();
      foreach (occ[i]) occ[i] = 0;
      bminx = 0; bmaxx = 0; bminy = 0; bmaxy = 0; bminz = 0; bmaxz = 0;
      loaded = 0;
    endfunction

    function int eff(int s);
      return s > Edge ? Edge : s;
    endfunction

    function bit in_grid(int x, int y, int z);
      return x >= 0 && y >= 0 && z >= 0 && x < eff(sx) && y < eff(sy) && z < eff(sz);
    endfunction

    function bit open_face(int x, int y, int z);
      if (!in_grid(x, y, z)) return 1;
      return !occ[(z*Edge + y)*Edge + x];
    endfunction

    // corners per face as {x, up, depth} picks, four per face
    function logic [2:0] corner(int d, int q);
      logic [11:0] c;
      case (d)
        0: c = 12'b100_110_111_101;
        1: c = 12'b001_011_010_000;
        2: c = 12'b001_101_111_011;
        3: c = 12'b100_000_010_110;
        4: c = 12'b010_011_111_110;
        default: c = 12'b001_000_100_101;
      endcase
      return c[11-3*q -: 3];
    endfunction

    function void note(word_t w);
      int x, y, z, n, d, k, x0, y0, z0, vy, slot;
      int shade[6];
      int order[6];
      logic [2:0] c;
      logic [31:0] pe;
      vertex_t v;
      shade = '{200, 200, 159, 159, 256, 128};
      order = '{0, 1, 2, 0, 2, 3};
      x = w.x; y = w.y; z = w.z;
      case (w.cmd)
        CMD_CLEAR: wipe();
        CMD_LOAD: if (in_grid(x, y, z)) begin
          occ[(z*Edge + y)*Edge + x] = 1;
          if (!loaded) begin
            bminx = x; bmaxx = x; bminy = y; bmaxy = y; bminz = z; bmaxz = z;
            loaded = 1;
          end else begin
            if (x < bminx) bminx = x;
            if (x > bmaxx) bmaxx = x;
            if (y < bminy) bminy = y;
            if (y > bmaxy) bmaxy = y;
            if (z < bminz) bminz = z;
            if (z > bmaxz) bmaxz = z;
          end
        end
        CMD_PAL: palette[w.ci] = w.rgba;
        CMD_REPORT: begin
          v = '{default: '0};
          v.last = 1;
          v.has = loaded;
          if (loaded) v.height = 6'(bmaxz - bminz + 1);
          pending.push_back(v);
        end
        CMD_EMIT: if (in_grid(x, y, z)) begin
          slot = w.ci > 0 ? w.ci - 1 : 0;
          pe = palette[slot];
          x0 = 2*x - (bminx + bmaxx + 1);
          y0 = 2*(z - bminz);
          z0 = 2*y - (bminy + bmaxy + 1);
          n = 0;
          for (d = 0; d < 6; d++) begin
            if (open_face(x + (d == 0) - (d == 1), y + (d == 2) - (d == 3),
                          z + (d == 4) - (d == 5))) begin
              for (k = 0; k < 6; k++) begin
                c = corner(d, order[k]);
                vy = y0 + 2*c[1];
                v = '{default: '0};
                v.vx = 8'(x0 + 2*c[2]);
                v.vy = vy < 0 ? 7'd0 : (vy > 127 ? 7'd127 : 7'(vy));
                v.vz = 8'(z0 + 2*c[0]);
                v.dir = 3'(d);
                v.r = 8'((int'(pe[7:0]) * shade[d]) >> 8);
                v.g = 8'((int'(pe[15:8]) * shade[d]) >> 8);
                v.b = 8'((int'(pe[23:16]) * shade[d]) >> 8);
                v.a = pe[31:24];
                pending.push_back(v);
                n++;
              end
            end
          end
          if (n > 0) pending[pending.size()-1].last = 1;
        end
        default: ;
      endcase
    endfunction

    function void check(vertex_t got);
      vertex_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, exp none, got vx=%0d vy=%0d", $time,
                 got.vx, got.vy);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        $display("%0t: mismatch exp vx=%0d vy=%0d vz=%0d dir=%0d rgba=%h%h%h%h last=%b h=%0d has=%b",
                 $time, $signed(e.vx), e.vy, $signed(e.vz), e.dir, e.a, e.b, e.g, e.r,
                 e.last, e.height, e.has);
        $display("%0t:          got vx=%0d vy=%0d vz=%0d dir=%0d rgba=%h%h%h%h last=%b h=%0d has=%b",
                 $time, $signed(got.vx), got.vy, $signed(got.vz), got.dir, got.a, got.b,
                 got.g, got.r, got.last, got.height, got.has);
        fails++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0, start = 0, busy, out_valid;
  logic [2:0] in_cmd = '0;
  logic [7:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0, in_color_index = '0;
  logic [31:0] in_palette_rgba = '0;
  logic signed [7:0] out_vert_x, out_vert_z;
  logic [6:0] out_vert_y;
  logic [2:0] out_face_dir;
  logic [7:0] out_red, out_green, out_blue, out_alpha;
  logic out_last, out_has_content;
  logic [5:0] out_content_height;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0, cfg_pready;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;

  mesh_scoreboard sb = new();
  int sent = 0, idle_cycles = 0;
  bit calm = 0;
  int slots[$];

  voxel_face_culling_mesher uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check('{out_vert_x, out_vert_y, out_vert_z, out_face_dir, out_red, out_green,
                   out_blue, out_alpha, out_last, out_content_height, out_has_content});
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send(word_t w);
    @(negedge clk);
    start = 1;
    in_cmd = w.cmd; in_coord_x = w.x; in_coord_y = w.y; in_coord_z = w.z;
    in_color_index = w.ci; in_palette_rgba = w.rgba;
    do @(posedge clk); while (busy);
    sb.note(w);
    if (w.cmd == CMD_PAL && w.ci != 8'd255) slots.push_back(w.ci);
    sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    start = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_size(reg_idx_t idx, int val);
    @(negedge clk);
    cfg_psel = 1; cfg_pwrite = 1; cfg_penable = 0;
    cfg_paddr = 4'(idx * 4);
    cfg_pwdata = {$urandom_range(0, 3) == 0 ? 26'($urandom) : 26'd0, 6'(val)};
    @(negedge clk);
    cfg_penable = 1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
    case (idx)
      REG_SIZE_X: sb.sx = val;
      REG_SIZE_Y: sb.sy = val;
      default: sb.sz = val;
    endcase
  endtask

  task automatic set_sizes(int a, int b, int c);
    settle();
    write_size(REG_SIZE_X, a);
    write_size(REG_SIZE_Y, b);
    write_size(REG_SIZE_Z, c);
  endtask

  function automatic word_t mk(logic [2:0] c, int x, int y, int z, int ci, logic [31:0] rgba);
    word_t w;
    w.cmd = c; w.x = 8'(x); w.y = 8'(y); w.z = 8'(z); w.ci = 8'(ci); w.rgba = rgba;
    return w;
  endfunction

  function automatic int pick(int s);
    int e;
    e = s > Edge ? Edge : s;
    if (e == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, e - 1);
  endfunction

  // colour index whose palette slot is known to be written
  function automatic int safe_ci();
    int s;
    s = slots[$urandom_range(0, slots.size() - 1)];
    return s == 0 ? $urandom_range(0, 1) : s + 1;
  endfunction

  task automatic model_burst();
    word_t vox[$];
    word_t w;
    int n, ox, oy, oz;
    send(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
    repeat ($urandom_range(1, 2))
      send(mk(CMD_PAL, 0, 0, 0, $urandom_range(0, 255), $urandom));
    ox = pick(sb.sx); oy = pick(sb.sy); oz = pick(sb.sz);
    n = $urandom_range(3, 10);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0)
        w = mk(CMD_LOAD, pick(sb.sx), pick(sb.sy), pick(sb.sz), safe_ci(), 0);
      else
        w = mk(CMD_LOAD, (ox + $urandom_range(0, 2)) % 256, (oy + $urandom_range(0, 2)) % 256,
               (oz + $urandom_range(0, 2)) % 256, safe_ci(), 0);
      send(w);
      vox.push_back(w);
    end
    if ($urandom_range(0, 3) == 0)
      send(mk($urandom_range(0, 7), $urandom, $urandom, $urandom, safe_ci(), $urandom));
    foreach (vox[i]) begin
      w = vox[i];
      w.cmd = CMD_EMIT;
      send(w);
    end
    if ($urandom_range(0, 2) == 0)
      send(mk(CMD_EMIT, pick(sb.sx), pick(sb.sy), pick(sb.sz), safe_ci(), 0));
    send(mk(CMD_REPORT, $urandom, $urandom, $urandom, $urandom, $urandom));
  endtask

  initial begin
    int phase;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    calm = 1;
    send(mk(CMD_PAL, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send(mk(CMD_PAL, 0, 0, 0, 254, 32'h0000_0000));
    send(mk(CMD_PAL, 0, 0, 0, 255, 32'h8040_C020));
    send(mk(CMD_PAL, 0, 0, 0, 1, 32'h12F0_0F81));
    send(mk(CMD_REPORT, 0, 0, 0, 0, 0));
    send(mk(CMD_EMIT, 0, 0, 0, 0, 0));
    send(mk(CMD_LOAD, 0, 0, 0, 0, 0));
    send(mk(CMD_LOAD, 31, 31, 31, 0, 0));
    send(mk(CMD_LOAD, 32, 0, 0, 0, 0));
    send(mk(CMD_LOAD, 255, 255, 255, 255, 0));
    send(mk(CMD_REPORT, 0, 0, 0, 0, 0));
    send(mk(CMD_EMIT, 0, 0, 0, 255, 0));
    send(mk(CMD_EMIT, 31, 31, 31, 1, 0));
    send(mk(CMD_LOAD, 1, 0, 0, 0, 0));
    send(mk(CMD_EMIT, 0, 0, 0, 2, 0));
    send(mk(CMD_EMIT, 255, 0, 0, 0, 0));
    send(mk(3'd5, 1, 1, 1, 1, 1));
    send(mk(3'd6, 2, 2, 2, 2, 2));
    send(mk(3'd7, 255, 255, 255, 255, 32'hFFFF_FFFF));
    send(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
    send(mk(CMD_LOAD, 0, 0, 5, 0, 0));
    send(mk(CMD_EMIT, 0, 0, 2, 1, 0));
    send(mk(CMD_REPORT, 0, 0, 0, 0, 0));
    calm = 0;
    phase = 0;
    while (sent < 330) begin
      if (sent > 270) calm = 1;
      if (sent >= 50 * (phase + 1)) begin
        case (phase)
          0: set_sizes(1, 1, 1);
          1: set_sizes(63, 63, 63);
          2: set_sizes(5, 7, 3);
          3: set_sizes(0, 4, 4);
          4: set_sizes($urandom_range(2, 40), $urandom_range(2, 40), $urandom_range(2, 40));
          default: set_sizes(32, 32, 32);
        endcase
        phase++;
      end
      model_burst();
      if ($urandom_range(0, 9) == 0) settle();
    end
    settle();
    if (sb.fails == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
